>>> src/tli_pkg.sv
// Shared types, widths and codes for the table linear interpolator.
package tli_pkg;

	localparam int VAL_W         = 32;
	localparam int IDX_W         = 6;
	localparam int CNT_W         = 7;
	localparam int STAT_W        = 2;
	localparam int DEPTH_DEFAULT = 64;

	localparam int MAG_W      = VAL_W + 1;
	localparam int SUM_W      = VAL_W + 2;
	localparam int RES_W      = VAL_W + 3;
	localparam int MUL_STEPS  = VAL_W;
	localparam int DIV_STEPS  = VAL_W + 1;
	localparam int STEP_W     = $clog2(DIV_STEPS + 1);

	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_W   = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BELOW      = 2'd1,
		STATUS_ABOVE      = 2'd2,
		STATUS_ZERO_WIDTH = 2'd3
	} status_t;

	typedef struct packed {
		logic start;
	} md_ctrl_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} md_stat_t;

endpackage

>>> src/tli_if.sv
// Item and answer channel interfaces of the table linear interpolator.
interface tli_item_if import tli_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic [IDX_W-1:0]        entry_index;
	logic signed [VAL_W-1:0] entry_x;
	logic signed [VAL_W-1:0] entry_y;
	logic signed [VAL_W-1:0] query_x;

	modport source (output valid, cmd, entry_index, entry_x, entry_y, query_x, input ready);
	modport sink (input valid, cmd, entry_index, entry_x, entry_y, query_x, output ready);
endinterface

interface tli_answer_if import tli_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] result_y;

	modport source (output valid, status, result_y, input ready);
	modport sink (input valid, status, result_y, output ready);
endinterface

>>> src/table_linear_interpolator_unit.sv
// Piecewise linear table interpolator over up to TABLE_DEPTH signed Q16.16 (x, y)
// points held in two RAMs. A write beat stores one point and is answered with status OK.
// A query beat scans the entries in order, through S_READ and S_CMP per entry
// visited because the table RAM read is registered, then runs one shared
// add/subtract stage first as a 32-step shift-add multiplier and then as a
// 33-step restoring divider; an out-of-range query ends when the scan does.
// The block takes one beat at a time and holds a finished answer in an output
// register, so a new beat is taken while that answer still waits. The table has no
// reset; the user must write entry_count through the APB port only while the block
// is idle, and the block itself does not enforce this.
module table_linear_interpolator_unit import tli_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	tli_item_if.sink           item,
	tli_answer_if.source       answer,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_CMP   = 6'b000100,
		S_SETUP = 6'b001000,
		S_MD    = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           i_q;
	logic signed [VAL_W-1:0] v_q;
	logic signed [VAL_W-1:0] x0_q;
	logic signed [VAL_W-1:0] y0_q;
	logic signed [VAL_W-1:0] x1_q;
	logic signed [VAL_W-1:0] y1_q;
	logic                    neg_q;
	logic [RES_W-1:0]        res_q;
	status_t                 stat_q;
	logic                    ovalid_q;
	logic [STAT_W-1:0]       ostatus_q;
	logic [VAL_W-1:0]        oresult_q;

	logic                    accept;
	logic                    cfg_wr;
	logic [IDX_W+AW-1:0]     idx_ext;
	logic                    idx_ok;
	logic [CNT_W+CW-1:0]     count_ext;
	logic [CW-1:0]           n_eff;
	logic [CW-1:0]           i_next;
	logic                    ram_we;
	logic [VAL_W-1:0]        rx;
	logic [VAL_W-1:0]        ry;
	logic signed [MAG_W-1:0] b_diff;
	logic signed [MAG_W-1:0] d_diff;
	logic signed [MAG_W-1:0] dy_diff;
	logic                    d_bad;
	md_ctrl_t                md_ctrl;
	md_stat_t                md_stat;
	logic [MAG_W-1:0]        quot;
	logic [RES_W-1:0]        res_next;
	logic [VAL_W-1:0]        res_sat;
	logic                    out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT);
	assign prdata = (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT)
		? {{(PDATA_W-CNT_W){1'b0}}, count_q} : '0;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	assign idx_ext   = {{AW{1'b0}}, item.entry_index};
	assign idx_ok    = idx_ext < (IDX_W+AW)'(TABLE_DEPTH);
	assign ram_we    = accept && (item.cmd == CMD_WRITE) && idx_ok;
	assign count_ext = {{CW{1'b0}}, count_q};
	assign n_eff     = (count_ext > (CNT_W+CW)'(TABLE_DEPTH))
		? CW'(TABLE_DEPTH) : count_ext[CW-1:0];
	assign i_next    = i_q + 1'b1;

	tli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_x (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata (item.entry_x),
		.raddr (i_q[AW-1:0]),
		.rdata (rx)
	);

	tli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_y (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata (item.entry_y),
		.raddr (i_q[AW-1:0]),
		.rdata (ry)
	);

	assign b_diff  = {v_q[VAL_W-1], v_q} - {x0_q[VAL_W-1], x0_q};
	assign d_diff  = {x1_q[VAL_W-1], x1_q} - {x0_q[VAL_W-1], x0_q};
	assign dy_diff = {y1_q[VAL_W-1], y1_q} - {y0_q[VAL_W-1], y0_q};
	assign d_bad   = d_diff[MAG_W-1] || (d_diff == '0);

	assign md_ctrl.start = (state_q == S_SETUP) && !d_bad;

	tli_muldiv u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (md_ctrl),
		.mplier  (b_diff[VAL_W-1:0]),
		.mcand   (dy_diff[MAG_W-1] ? MAG_W'(-dy_diff) : MAG_W'(dy_diff)),
		.divisor (d_diff[VAL_W-1:0]),
		.stat    (md_stat),
		.quot    (quot)
	);

	// A negative slope rounds toward minus infinity: y0 - q, less one more on a remainder.
	assign res_next = {{(RES_W-VAL_W){y0_q[VAL_W-1]}}, y0_q}
		+ (neg_q ? ~{2'b00, quot} : {2'b00, quot})
		+ RES_W'(neg_q && !md_stat.rem_nz);

	assign res_sat = (res_q[RES_W-1:VAL_W-1] == '0 || res_q[RES_W-1:VAL_W-1] == '1)
		? res_q[VAL_W-1:0]
		: (res_q[RES_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

	assign out_free = !ovalid_q || answer.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				count_q <= pwdata[CNT_W-1:0];
			end
			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (answer.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_QUERY && n_eff != '0) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ($signed(rx) > v_q) begin
						state_q <= (i_q == '0) ? S_DONE : S_SETUP;
					end else begin
						state_q <= (i_next == n_q) ? S_DONE : S_READ;
					end
				end
				S_SETUP: begin
					state_q <= d_bad ? S_DONE : S_MD;
				end
				S_MD: begin
					if (md_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					v_q   <= item.query_x;
					n_q   <= n_eff;
					i_q   <= '0;
					res_q <= '0;
					stat_q <= (item.cmd == CMD_QUERY && n_eff == '0) ? STATUS_BELOW : STATUS_OK;
				end
			end
			S_CMP: begin
				if ($signed(rx) > v_q) begin
					x1_q <= rx;
					y1_q <= ry;
					if (i_q == '0) begin
						stat_q <= STATUS_BELOW;
					end
				end else begin
					x0_q <= rx;
					y0_q <= ry;
					i_q  <= i_next;
					if (i_next == n_q) begin
						stat_q <= STATUS_ABOVE;
					end
				end
			end
			S_SETUP: begin
				neg_q <= dy_diff[MAG_W-1];
				if (d_bad) begin
					stat_q <= STATUS_ZERO_WIDTH;
				end
			end
			S_MD: begin
				if (md_stat.done) begin
					res_q <= res_next;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ostatus_q <= stat_q;
					oresult_q <= res_sat;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign answer.valid    = ovalid_q;
	assign answer.status   = ostatus_q;
	assign answer.result_y = oresult_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> i_q < n_q)
		else $error("scan index past the entries in use");

	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		md_stat.done |-> state_q == S_MD)
		else $error("arithmetic unit finished outside of a query");

	a_error_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		answer.valid && answer.status != STATUS_OK |-> answer.result_y == '0)
		else $error("error answer carries a nonzero result");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item.ready)
		else $error("second beat taken before the first finished");

endmodule

>>> src/tli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/tli_muldiv.sv
// Iterative multiply-then-divide unit built around one shared add/subtract stage.
module tli_muldiv import tli_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  md_ctrl_t         ctrl,
	input  logic [VAL_W-1:0] mplier,
	input  logic [MAG_W-1:0] mcand,
	input  logic [VAL_W-1:0] divisor,
	output md_stat_t         stat,
	output logic [MAG_W-1:0] quot
);

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_MUL  = 5'b00010,
		M_XFER = 5'b00100,
		M_DIV  = 5'b01000,
		M_DONE = 5'b10000
	} md_state_t;

	md_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0] acc_q;
	logic [MAG_W-1:0] sh_q;
	logic [MAG_W-1:0] mcand_q;
	logic [VAL_W-1:0] div_q;

	logic [SUM_W-1:0] add_a;
	logic [SUM_W-1:0] add_b;
	logic             add_sub;
	logic [SUM_W-1:0] add_sum;
	logic [MAG_W-1:0] trial;
	logic             ge;

	assign trial = {acc_q[VAL_W-1:0], sh_q[MAG_W-1]};

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			M_MUL: begin
				add_a = {1'b0, acc_q};
				add_b = sh_q[0] ? {1'b0, mcand_q} : '0;
			end
			M_DIV: begin
				add_a   = {1'b0, trial};
				add_b   = {2'b00, div_q};
				add_sub = 1'b1;
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + SUM_W'(add_sub);
	assign ge      = !add_sum[SUM_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (ctrl.start) begin
						state_q <= M_MUL;
						step_q  <= '0;
					end
				end
				M_MUL: begin
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						state_q <= M_XFER;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				M_XFER: begin
					state_q <= M_DIV;
				end
				M_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= M_DONE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				M_DONE: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (ctrl.start) begin
					acc_q   <= '0;
					sh_q    <= {1'b0, mplier};
					mcand_q <= mcand;
					div_q   <= divisor;
				end
			end
			M_MUL: begin
				acc_q <= add_sum[SUM_W-1:1];
				sh_q  <= {1'b0, add_sum[0], sh_q[VAL_W-1:1]};
			end
			M_XFER: begin
				acc_q <= {1'b0, acc_q[MAG_W-1:1]};
				sh_q  <= {acc_q[0], sh_q[VAL_W-1:0]};
			end
			M_DIV: begin
				acc_q <= {1'b0, ge ? add_sum[VAL_W-1:0] : trial[VAL_W-1:0]};
				sh_q  <= {sh_q[VAL_W-1:0], ge};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign stat.done   = (state_q == M_DONE);
	assign stat.rem_nz = |acc_q[VAL_W-1:0];
	assign quot        = sh_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == M_DIV |=> acc_q[VAL_W-1:0] < div_q)
		else $error("remainder reached the divisor");

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> state_q == M_IDLE)
		else $error("start while the unit is busy");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == M_DONE |-> $past(state_q) == M_DIV)
		else $error("done without a finished division");

endmodule

>>> test/tli_checker.sv
// Checker that mirrors the interpolator table, predicts every answer and compares it.
module tli_checker import tli_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	tli_item_if                item,
	tli_answer_if              answer,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int                 outstanding,
	output int                 mismatches
);

	typedef longint unsigned u64_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] y;
	} answer_t;

	localparam longint Y_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
	localparam longint Y_MIN = -(64'sd1 <<< (VAL_W - 1));

	logic signed [VAL_W-1:0] point_x [TABLE_DEPTH];
	logic signed [VAL_W-1:0] point_y [TABLE_DEPTH];
	logic [CNT_W-1:0]        used_count = '0;
	answer_t                 answers_due [$];
	int                      fault_count = 0;

	function automatic void log_fault(string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endfunction

	function automatic answer_t interpolate_at(logic signed [VAL_W-1:0] v);
		int      span;
		int      hit;
		longint  x0, x1, y0, y1, width, offset, rise, res;
		u64_t    wide_b, wide_r, mag, quo;
		answer_t ans;
		ans = '{status: STATUS_OK, y: '0};
		span = (int'(used_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(used_count);
		hit = span;
		for (int k = span - 1; k >= 0; k--) begin
			if (point_x[k] > v) begin
				hit = k;
			end
		end
		if (hit == 0) begin
			ans.status = STATUS_BELOW;
		end else if (hit == span) begin
			ans.status = STATUS_ABOVE;
		end else begin
			x0 = point_x[hit-1];
			y0 = point_y[hit-1];
			x1 = point_x[hit];
			y1 = point_y[hit];
			width = x1 - x0;
			if (width <= 0) begin
				ans.status = STATUS_ZERO_WIDTH;
			end else begin
				offset = longint'(v) - x0;
				rise = y1 - y0;
				wide_b = offset;
				wide_r = (rise < 0) ? -rise : rise;
				mag = wide_b * wide_r;
				quo = mag / u64_t'(width);
				if (rise < 0) begin
					if (mag % u64_t'(width) != 0) begin
						quo++;
					end
					res = y0 - longint'(quo);
				end else begin
					res = y0 + longint'(quo);
				end
				if (res > Y_MAX) begin
					res = Y_MAX;
				end
				if (res < Y_MIN) begin
					res = Y_MIN;
				end
				ans.y = res[VAL_W-1:0];
			end
		end
		return ans;
	endfunction

	always @(posedge clk) begin : watch
		answer_t due;
		if (arst_n) begin
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_ENTRY_COUNT) begin
				if (pwrite) begin
					used_count = pwdata[CNT_W-1:0];
				end else if (prdata !== PDATA_W'(used_count)) begin
					log_fault($sformatf("entry_count read expected %0d got %0d",
						used_count, prdata));
				end
			end
			if (answer.valid && answer.ready) begin
				if (answers_due.size() == 0) begin
					log_fault($sformatf("answer beat with none expected: status %0d result_y %0d",
						answer.status, answer.result_y));
				end else begin
					due = answers_due.pop_front();
					if (answer.status !== due.status) begin
						log_fault($sformatf("status expected %0d got %0d",
							due.status, answer.status));
					end
					if (answer.result_y !== due.y) begin
						log_fault($sformatf("result_y expected %0d got %0d",
							due.y, answer.result_y));
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.cmd == CMD_WRITE) begin
					if (int'(item.entry_index) < TABLE_DEPTH) begin
						point_x[item.entry_index] = item.entry_x;
						point_y[item.entry_index] = item.entry_y;
					end
					answers_due.push_back('{status: STATUS_OK, y: '0});
				end else begin
					answers_due.push_back(interpolate_at(item.query_x));
				end
			end
		end
		outstanding <= answers_due.size();
		mismatches <= fault_count;
	end

endmodule

>>> test/tb_table_linear_interpolator_unit.sv
// Testbench top: drives table writes, queries and entry_count settings, and reports the verdict.
module tb_table_linear_interpolator_unit;
	import tli_pkg::*;

	localparam int     DEPTH        = DEPTH_DEFAULT;
	localparam int     ITEMS_WANTED = 1700;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     TAIL_CYCLES  = 256;
	localparam int     CYCLE_LIMIT  = 3_000_000;
	localparam longint X_MAX        = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
	localparam longint X_MIN        = -(64'sd1 <<< (VAL_W - 1));
	localparam logic signed [VAL_W-1:0] Q_MAX = X_MAX[VAL_W-1:0];
	localparam logic signed [VAL_W-1:0] Q_MIN = X_MIN[VAL_W-1:0];
	localparam logic [PADDR_W-1:0]      COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 outstanding;
	int                 mismatch_count;
	int unsigned        cycle_count = 0;

	logic signed [VAL_W-1:0] mirror_x [DEPTH];
	bit                      written [DEPTH];
	bit                      calm = 1'b0;
	bit                      hold_request = 1'b0;
	bit                      hold_done = 1'b0;
	int                      sent = 0;

	tli_item_if   item_ch ();
	tli_answer_if answer_ch ();

	table_linear_interpolator_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.answer  (answer_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tli_checker #(.TABLE_DEPTH(DEPTH)) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.answer      (answer_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.outstanding (outstanding),
		.mismatches  (mismatch_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** table_linear_interpolator_unit: FAILED **");
		$finish;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic longint rand_wide();
		return {32'h0, $urandom()};
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp_q(longint wide);
		if (wide > X_MAX) begin
			return Q_MAX;
		end
		if (wide < X_MIN) begin
			return Q_MIN;
		end
		return wide[VAL_W-1:0];
	endfunction

	task automatic send(logic cmd, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] ex,
			logic signed [VAL_W-1:0] ey, logic signed [VAL_W-1:0] qx);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.cmd         <= cmd;
		item_ch.entry_index <= idx;
		item_ch.entry_x     <= ex;
		item_ch.entry_y     <= ey;
		item_ch.query_x     <= qx;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		sent++;
		if (cmd == CMD_WRITE) begin
			written[idx] = 1'b1;
			mirror_x[idx] = ex;
		end
	endtask

	task automatic write_point(int idx, logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] y);
		send(CMD_WRITE, IDX_W'(idx), x, y, $urandom());
	endtask

	task automatic query(logic signed [VAL_W-1:0] v);
		send(CMD_QUERY, IDX_W'($urandom()), $urandom(), $urandom(), v);
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_access(logic wr, logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= COUNT_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_count(int value);
		reg_access(1'b1, PDATA_W'(value));
		reg_access(1'b0, '0);
	endtask

	initial begin : drain
		int gap;
		answer_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				answer_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = draw_gap();
			if (gap > 0) begin
				answer_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			answer_ch.ready <= 1'b1;
			do @(posedge clk); while (answer_ch.valid !== 1'b1);
		end
	end

	initial begin : stimulus
		logic signed [VAL_W-1:0] xs [DEPTH];
		logic signed [VAL_W-1:0] ys [DEPTH];
		logic signed [VAL_W-1:0] v;
		longint                  lim, span, cur, lo, hi;
		int                      phase, k, count, n, limit, rot, nq, r, j, a, b, ymode;
		item_ch.valid       <= 1'b0;
		item_ch.cmd         <= CMD_WRITE;
		item_ch.entry_index <= '0;
		item_ch.entry_x     <= '0;
		item_ch.entry_y     <= '0;
		item_ch.query_x     <= '0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_count(0);
		query(32'sd0);
		query(Q_MIN);
		query(Q_MAX);
		write_point(0, Q_MIN, Q_MAX);
		write_point(1, -32'sd65536, Q_MIN);
		write_point(2, 32'sd0, 32'sd0);
		write_point(3, Q_MAX, Q_MAX);
		write_point(DEPTH - 1, 32'h5555_5555, 32'hAAAA_AAAA);
		settle();
		set_count(4);
		query(Q_MIN);
		query(-32'sd65536);
		query(-32'sd65537);
		query(-32'sd1);
		query(32'sh7FFF_FFFE);
		query(Q_MAX);
		settle();
		set_count(1);
		query(Q_MIN);
		query(32'sd0);
		settle();

		phase = 0;
		while (sent < ITEMS_WANTED) begin
			phase++;
			calm = ($urandom_range(0, 3) == 0);
			k = (phase == 1 || $urandom_range(0, 9) == 0) ? DEPTH : $urandom_range(2, 8);
			case ($urandom_range(0, 2))
				0: lim = (64'sd4294967296 - 64'sd128) / k;
				1: lim = 64'sd1 <<< $urandom_range(1, 24);
				default: lim = $urandom_range(1, 4);
			endcase
			span = 64'sd4294967296 - longint'(k) * lim;
			cur = X_MIN + rand_wide() % span;
			ymode = $urandom_range(0, 3);
			for (j = 0; j < k; j++) begin
				xs[j] = cur[VAL_W-1:0];
				cur += 1 + rand_wide() % lim;
				case (ymode)
					0: ys[j] = (j % 2 == 0) ? Q_MIN : Q_MAX;
					1: ys[j] = j * 32'sd65536 - 32'sd100000;
					default: ys[j] = $urandom();
				endcase
			end
			if ($urandom_range(0, 7) == 0) begin
				a = $urandom_range(0, k - 1);
				b = $urandom_range(0, k - 1);
				v = xs[a];
				xs[a] = xs[b];
				xs[b] = v;
			end
			rot = $urandom_range(0, k - 1);
			for (j = 0; j < k; j++) begin
				write_point((rot + j) % k, xs[(rot + j) % k], ys[(rot + j) % k]);
			end
			settle();

			limit = 0;
			while (limit < DEPTH && written[limit]) limit++;
			count = k;
			if ($urandom_range(0, 5) == 0) begin
				count = (limit == DEPTH) ? $urandom_range(0, 127) : $urandom_range(0, limit);
			end
			if (k == DEPTH && $urandom_range(0, 1) == 0) begin
				count = $urandom_range(DEPTH, 127);
			end
			if (phase == 1) begin
				count = 127;
			end
			set_count(count);
			n = (count > DEPTH) ? DEPTH : count;
			if (phase == 2) begin
				hold_request = 1'b1;
			end

			nq = (n > 16) ? $urandom_range(10, 25) : $urandom_range(15, 45);
			repeat (nq) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					write_point($urandom_range(0, DEPTH - 1), $urandom(), $urandom());
				end else begin
					if (n >= 2 && r < 70) begin
						j = $urandom_range(0, n - 2);
						lo = mirror_x[j];
						hi = mirror_x[j + 1];
						v = (hi > lo) ? clamp_q(lo + rand_wide() % (hi - lo)) : mirror_x[j];
					end else if (n >= 1 && r < 80) begin
						v = mirror_x[$urandom_range(0, n - 1)];
					end else if (n >= 1 && r < 88) begin
						v = clamp_q(longint'(mirror_x[0]) - 1 - $urandom_range(0, 255));
					end else if (n >= 1 && r < 92) begin
						v = clamp_q(longint'(mirror_x[n - 1]) + $urandom_range(0, 255));
					end else begin
						case ($urandom_range(0, 2))
							0: v = Q_MIN;
							1: v = Q_MAX;
							default: v = $urandom();
						endcase
					end
					query(v);
				end
			end
			settle();
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("** table_linear_interpolator_unit: PASSED **");
		end else begin
			$display("** table_linear_interpolator_unit: FAILED **");
		end
		$finish;
	end

endmodule
